FILE: rtl/core/cci_pkg.sv
// Shared types and constants for the commodity channel index block.
// Used by cci_cell, cci_div and commodity_channel_index; depends on nothing.
package cci_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TP,
    ST_LOAD,
    ST_SUM,
    ST_DEV,
    ST_FLUSH,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam int PRICE_W  = 32;
  localparam int SUM3_W   = 34;
  localparam int TP_STEPS = SUM3_W / 2;
  localparam int TP_CNT_W = 5;
  localparam int FRAC_W   = 16;
  localparam int QUOT_W   = 32;
  localparam int QCNT_W   = 5;
  localparam int LEN_W    = 7;

  localparam logic [LEN_W-1:0]   LEN_RESET = 7'd20;
  localparam logic [QUOT_W-1:0]  INDEX_MAX = 32'h7FFF_FFFF;
  localparam logic [QUOT_W-1:0]  INDEX_MIN = 32'h8000_0000;

  function automatic logic [1:0] div3_digit(input logic [3:0] t);
    logic [1:0] d;
    if (t >= 4'd9) begin
      d = 2'd3;
    end else if (t >= 4'd6) begin
      d = 2'd2;
    end else if (t >= 4'd3) begin
      d = 2'd1;
    end else begin
      d = 2'd0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/cci_cell.sv
// One cell of the typical price chain: holds one price and passes it on.
// Depends on cci_pkg for the price width.
module cci_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [cci_pkg::PRICE_W-1:0]  d,
  output logic [cci_pkg::PRICE_W-1:0]  q
);

  logic [cci_pkg::PRICE_W-1:0] price;

  always_ff @(posedge clk) begin
    if (shift) begin
      price <= d;
    end
  end

  assign q = price;

endmodule

FILE: rtl/core/cci_div.sv
// Restoring divider giving one quotient bit per cycle.
// Depends on cci_pkg for the quotient width and counter width.
module cci_div #(
  parameter int DW = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               rem_init,
  input  logic [cci_pkg::QUOT_W-1:0]  low_bits,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [cci_pkg::QUOT_W-1:0]  quotient
);

  logic                        busy;
  logic [cci_pkg::QCNT_W-1:0]  cnt;
  logic [DW-1:0]               rem;
  logic [cci_pkg::QUOT_W-1:0]  lo;
  logic [cci_pkg::QUOT_W-1:0]  quo;
  logic [DW:0]                 trial;
  logic                        ge;

  assign trial = {rem, lo[cci_pkg::QUOT_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cci_pkg::QCNT_W'(cci_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      lo  <= low_bits;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      lo  <= {lo[cci_pkg::QUOT_W-2:0], 1'b0};
      quo <= {quo[cci_pkg::QUOT_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/core/commodity_channel_index.sv
// Commodity channel index over a sliding window of price bars, top level.
// Depends on cci_pkg, cci_cell and cci_div.
// Each bar passes through the divide by three, two full rotations of the price cell chain
// (one for the sum, one for the deviation) and the serial divider from acceptance to
// result. A bar that leaves the window short of full skips straight to the output. A bar
// with zero deviation or an out-of-range value skips the divider.
// Writing window_length clears the window.
module commodity_channel_index #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          window_length,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         bar_high,
  input  logic [31:0]         bar_low,
  input  logic [31:0]         bar_close,
  input  logic                start_series,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                ready_res,
  output logic signed [31:0]  index_value,
  output logic                zero_deviation,
  output logic                saturated
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = cci_pkg::PRICE_W + AW;
  localparam int DW = SW + AW;
  localparam int MW = SW + LW + 8;
  localparam int NW = DW + 2;
  localparam int XW = ((MW > NW + cci_pkg::FRAC_W) ? MW : NW + cci_pkg::FRAC_W) + 1;

  cci_pkg::state_t state, state_next;

  logic [cci_pkg::LEN_W-1:0]     len_reg;
  logic [LW-1:0]                 n_eff;
  logic [LW-1:0]                 fill;
  logic [LW-1:0]                 fill_inc;
  logic                          full;

  logic [cci_pkg::SUM3_W-1:0]    x3;
  logic [1:0]                    r3;
  logic [cci_pkg::SUM3_W-1:0]    q3;
  logic [cci_pkg::TP_CNT_W-1:0]  tcnt;
  logic [3:0]                    t4;
  logic [1:0]                    dig;
  logic [cci_pkg::PRICE_W-1:0]   tp;

  logic [cci_pkg::PRICE_W-1:0]   cq [WINDOW_MAX];
  logic [cci_pkg::PRICE_W-1:0]   cd [WINDOW_MAX];
  logic [cci_pkg::PRICE_W-1:0]   cell_last;
  logic                          shift_en;

  logic [AW-1:0]                 wk;
  logic                          in_win;
  logic                          wk_last;
  logic [SW-1:0]                 s;
  logic [SW-1:0]                 prod;
  logic                          pv;
  logic [SW-1:0]                 absdiff;
  logic [DW-1:0]                 dacc;
  logic [SW-1:0]                 ntp;
  logic [SW-1:0]                 mag;
  logic                          neg;
  logic [MW-1:0]                 p1;
  logic [MW-1:0]                 num;
  logic [NW-1:0]                 den;
  logic                          zero_r;
  logic                          ovf_c;
  logic                          ovf;
  logic                          div_start;
  logic                          div_done;
  logic [cci_pkg::QUOT_W-1:0]    quo;
  logic                          out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != cci_pkg::ST_IDLE);

  always_comb begin
    if (len_reg == '0) begin
      n_eff = LW'(1);
    end else if (32'(len_reg) > WINDOW_MAX) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = LW'(len_reg);
    end
  end

  assign fill_inc = (fill < n_eff) ? fill + 1'b1 : fill;

  assign t4  = {r3, x3[cci_pkg::SUM3_W-1 -: 2]};
  assign dig = cci_pkg::div3_digit(t4);
  assign tp  = q3[cci_pkg::PRICE_W-1:0];

  assign cell_last = cq[WINDOW_MAX-1];
  assign shift_en  = (state == cci_pkg::ST_LOAD) || (state == cci_pkg::ST_SUM) ||
                     (state == cci_pkg::ST_DEV);
  assign cd[0]     = (state == cci_pkg::ST_LOAD) ? tp : cell_last;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_chain
    if (i > 0) begin : g_link
      assign cd[i] = cq[i-1];
    end
    cci_cell u_cell (
      .clk   (clk),
      .shift (shift_en),
      .d     (cd[i]),
      .q     (cq[i])
    );
  end

  assign in_win  = (32'(WINDOW_MAX - 1) - 32'(wk)) < 32'(n_eff);
  assign wk_last = (wk == AW'(WINDOW_MAX - 1));
  assign absdiff = (prod >= s) ? prod - s : s - prod;
  assign mag     = (ntp >= s) ? ntp - s : s - ntp;
  assign ovf_c   = XW'(num) >= (XW'(den) << cci_pkg::FRAC_W);

  assign div_start = (state == cci_pkg::ST_CHECK) && !zero_r && !ovf_c;
  assign out_load  = (state == cci_pkg::ST_OUT) && (!out_valid || !out_stall);

  cci_div #(
    .DW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (NW'(num >> cci_pkg::FRAC_W)),
    .low_bits ({num[cci_pkg::FRAC_W-1:0], {cci_pkg::FRAC_W{1'b0}}}),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cci_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cci_pkg::ST_TP;
        end
      end
      cci_pkg::ST_TP: begin
        if (tcnt == cci_pkg::TP_CNT_W'(cci_pkg::TP_STEPS - 1)) begin
          state_next = cci_pkg::ST_LOAD;
        end
      end
      cci_pkg::ST_LOAD: begin
        state_next = (fill_inc == n_eff) ? cci_pkg::ST_SUM : cci_pkg::ST_OUT;
      end
      cci_pkg::ST_SUM: begin
        if (wk_last) begin
          state_next = cci_pkg::ST_DEV;
        end
      end
      cci_pkg::ST_DEV: begin
        if (wk_last) begin
          state_next = cci_pkg::ST_FLUSH;
        end
      end
      cci_pkg::ST_FLUSH: state_next = cci_pkg::ST_MUL1;
      cci_pkg::ST_MUL1:  state_next = cci_pkg::ST_MUL2;
      cci_pkg::ST_MUL2:  state_next = cci_pkg::ST_CHECK;
      cci_pkg::ST_CHECK: begin
        state_next = (zero_r || ovf_c) ? cci_pkg::ST_OUT : cci_pkg::ST_DIV;
      end
      cci_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = cci_pkg::ST_OUT;
        end
      end
      cci_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = cci_pkg::ST_IDLE;
        end
      end
      default: state_next = cci_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg   <= cci_pkg::LEN_RESET;
      fill      <= '0;
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_reg <= window_length;
        fill    <= '0;
      end else if (state == cci_pkg::ST_IDLE && in_valid && start_series) begin
        fill <= '0;
      end else if (state == cci_pkg::ST_LOAD) begin
        fill <= fill_inc;
        full <= (fill_inc == n_eff);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cci_pkg::ST_IDLE: begin
        x3   <= cci_pkg::SUM3_W'(bar_high) + cci_pkg::SUM3_W'(bar_low) +
                cci_pkg::SUM3_W'(bar_close);
        r3   <= '0;
        tcnt <= '0;
      end
      cci_pkg::ST_TP: begin
        x3   <= {x3[cci_pkg::SUM3_W-3:0], 2'b00};
        r3   <= 2'(t4 - (4'({2'b00, dig}) + 4'({1'b0, dig, 1'b0})));
        q3   <= {q3[cci_pkg::SUM3_W-3:0], dig};
        tcnt <= tcnt + 1'b1;
      end
      cci_pkg::ST_LOAD: begin
        s  <= '0;
        wk <= '0;
      end
      cci_pkg::ST_SUM: begin
        if (in_win) begin
          s <= s + SW'(cell_last);
        end
        wk   <= wk + 1'b1;
        pv   <= 1'b0;
        dacc <= '0;
      end
      cci_pkg::ST_DEV: begin
        prod <= SW'(cell_last) * SW'(n_eff);
        pv   <= in_win;
        if (pv) begin
          dacc <= dacc + DW'(absdiff);
        end
        wk <= wk + 1'b1;
      end
      cci_pkg::ST_FLUSH: begin
        if (pv) begin
          dacc <= dacc + DW'(absdiff);
        end
        pv  <= 1'b0;
        ntp <= SW'(tp) * SW'(n_eff);
      end
      cci_pkg::ST_MUL1: begin
        neg <= ntp < s;
        p1  <= MW'(mag) * MW'(n_eff);
      end
      cci_pkg::ST_MUL2: begin
        num    <= (p1 << 7) + (p1 << 6) + (p1 << 3);
        den    <= (NW'(dacc) << 1) + NW'(dacc);
        zero_r <= (dacc == '0);
      end
      cci_pkg::ST_CHECK: begin
        ovf <= ovf_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ready_res      <= full;
      zero_deviation <= full && zero_r;
      if (!full || zero_r) begin
        index_value <= '0;
        saturated   <= 1'b0;
      end else if (!neg) begin
        if (ovf || quo[cci_pkg::QUOT_W-1]) begin
          index_value <= $signed(cci_pkg::INDEX_MAX);
          saturated   <= 1'b1;
        end else begin
          index_value <= $signed(quo);
          saturated   <= 1'b0;
        end
      end else begin
        if (ovf || quo > cci_pkg::INDEX_MIN) begin
          index_value <= $signed(cci_pkg::INDEX_MIN);
          saturated   <= 1'b1;
        end else begin
          index_value <= $signed(cci_pkg::QUOT_W'(0) - quo);
          saturated   <= 1'b0;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= n_eff)
    else $error("fill count exceeds window length");

  a_zero_dev: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_deviation |-> index_value == 0 && !saturated && ready_res)
    else $error("zero deviation item carries a value");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      index_value == $signed(cci_pkg::INDEX_MAX) ||
      index_value == $signed(cci_pkg::INDEX_MIN))
    else $error("saturated item not clamped");

  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready_res |-> index_value == 0 && !saturated && !zero_deviation)
    else $error("item before full window carries data");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    state == cci_pkg::ST_SUM && wk_last |=> state == cci_pkg::ST_DEV && wk == '0)
    else $error("sum walk did not hand over to deviation walk");

endmodule

FILE: tb/cci_checker.sv
// Checker for the commodity channel index block: watches the register, bar and result
// channels, predicts each result from its own window model and compares field by field.
// Depends on nothing but the signals it is connected to.
module cci_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         window_length,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        bar_high,
  input  logic [31:0]        bar_low,
  input  logic [31:0]        bar_close,
  input  logic               start_series,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               ready_res,
  input  logic signed [31:0] index_value,
  input  logic               zero_deviation,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  localparam int SPAN_MAX = 64;

  typedef struct packed {
    logic        ready;
    logic [31:0] value;
    logic        zdev;
    logic        sat;
  } cci_result_t;

  cci_result_t     expected_cci[$];
  logic [31:0]     tp_ring[SPAN_MAX];
  logic [63:0]     ring_total;
  int unsigned     bars_held;
  int unsigned     next_slot;
  logic [6:0]      span_reg;

  function automatic int unsigned span_used();
    int unsigned n;
    n = span_reg;
    if (n < 1) n = 1;
    if (n > SPAN_MAX) n = SPAN_MAX;
    return n;
  endfunction

  function automatic cci_result_t predict_cci(logic [31:0] h, logic [31:0] l,
                                              logic [31:0] c, logic restart);
    cci_result_t r;
    int unsigned n, slot;
    logic [63:0] tp, ntp, dev, mag, num, den, q, rem, frac, v;
    logic neg;
    n = span_used();
    tp = ({32'd0, h} + {32'd0, l} + {32'd0, c}) / 64'd3;
    r = '0;
    if (restart || bars_held > n) begin
      ring_total = 0;
      bars_held = 0;
      next_slot = 0;
    end
    slot = next_slot;
    if (slot >= n) slot = 0;
    if (bars_held < n) bars_held++;
    else ring_total -= tp_ring[slot];
    tp_ring[slot] = tp[31:0];
    ring_total += tp;
    slot++;
    if (slot >= n) slot = 0;
    next_slot = slot;
    if (bars_held < n) return r;
    r.ready = 1'b1;
    ntp = n * tp;
    neg = ntp < ring_total;
    dev = 0;
    for (int k = 0; k < n; k++) begin
      v = n * {32'd0, tp_ring[k]};
      dev += (v >= ring_total) ? v - ring_total : ring_total - v;
    end
    if (dev == 0) begin
      r.zdev = 1'b1;
      return r;
    end
    mag = neg ? ring_total - ntp : ntp - ring_total;
    num = mag * n * 200;
    den = 3 * dev;
    q = num / den;
    rem = num % den;
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem -= den;
        frac |= 1;
      end
    end
    if (!neg) begin
      if (q >= 32768) begin
        r.value = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.value = ((q << 16) | frac);
      end
    end else begin
      if (q > 32768 || (q == 32768 && frac != 0)) begin
        r.value = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.value = 32'd0 - ((q << 16) | frac);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH result %0d %s: expected %h, got %h", result_count, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cci_result_t want;
    if (rst) begin
      expected_cci.delete();
      ring_total = 0;
      bars_held = 0;
      next_slot = 0;
      span_reg = 7'd20;
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        span_reg = window_length;
        ring_total = 0;
        bars_held = 0;
        next_slot = 0;
      end
      if (in_valid && !in_stall) begin
        expected_cci.insert(expected_cci.size(),
                            predict_cci(bar_high, bar_low, bar_close, start_series));
      end
      if (out_valid && !out_stall) begin
        if (expected_cci.size() == 0) begin
          report_mismatch("item with nothing expected", '0, '0);
        end else begin
          want = expected_cci.pop_front();
          if (want.ready !== ready_res) report_mismatch("ready_res", want.ready, ready_res);
          if (want.value !== index_value) report_mismatch("index_value", want.value, index_value);
          if (want.zdev !== zero_deviation)
            report_mismatch("zero_deviation", want.zdev, zero_deviation);
          if (want.sat !== saturated) report_mismatch("saturated", want.sat, saturated);
        end
        result_count++;
      end
    end
    pending_count = expected_cci.size();
  end

endmodule

FILE: tb/tb_commodity_channel_index.sv
// Top of the commodity channel index testbench: drives window settings and price bars
// with random gaps and output stalls, and gives the verdict from cci_checker.
// Depends on commodity_channel_index and cci_checker.
module tb_commodity_channel_index;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] window_length = 7'd20;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] bar_high = '0;
  logic [31:0] bar_low = '0;
  logic [31:0] bar_close = '0;
  logic start_series = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ready_res;
  logic signed [31:0] index_value;
  logic zero_deviation;
  logic saturated;
  int fail_count, pending_count, result_count;
  int cycles = 0;
  int bars_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;

  commodity_channel_index dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length),
    .in_valid(in_valid), .in_stall(in_stall),
    .bar_high(bar_high), .bar_low(bar_low), .bar_close(bar_close),
    .start_series(start_series),
    .out_valid(out_valid), .out_stall(out_stall),
    .ready_res(ready_res), .index_value(index_value),
    .zero_deviation(zero_deviation), .saturated(saturated)
  );

  cci_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length),
    .in_valid(in_valid), .in_stall(in_stall),
    .bar_high(bar_high), .bar_low(bar_low), .bar_close(bar_close),
    .start_series(start_series),
    .out_valid(out_valid), .out_stall(out_stall),
    .ready_res(ready_res), .index_value(index_value),
    .zero_deviation(zero_deviation), .saturated(saturated),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: before each result, hold stall for a random number of cycles.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      repeat (hold) begin
        @(posedge clk);
        out_stall <= 1'b1;
      end
      @(posedge clk);
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c, logic restart);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    bar_high <= h;
    bar_low <= l;
    bar_close <= c;
    start_series <= restart;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    bars_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_window(logic [6:0] n);
    cfg_valid <= 1'b1;
    window_length <= n;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_bars(int count);
    logic [31:0] base;
    int shape;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
        base = base + $urandom_range(0, 4095) - 2048;
        send_bar(base + $urandom_range(0, 255), base - $urandom_range(0, 255),
                 base + $urandom_range(0, 511) - 256, $urandom_range(0, 60) == 0);
      end else if (shape < 8) begin
        send_bar($urandom, $urandom, $urandom, $urandom_range(0, 30) == 0);
      end else if (shape < 9) begin
        send_bar(base, base, base, 1'b0);
      end else begin
        send_bar(base << $urandom_range(0, 8), $urandom_range(0, 3), base, 1'b0);
      end
    end
  endtask

  initial begin
    logic [6:0] lengths[6];
    lengths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd20};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at the reset window length, a restart, then a flat series.
    send_bar('1, '1, '1, 1'b0);
    send_bar('0, '0, '0, 1'b0);
    for (int i = 0; i < 20; i++) send_bar(32'h0001_0000 * i, 32'h10, 32'h0, 1'b0);
    send_bar('1, 32'h0, '1, 1'b1);
    for (int i = 0; i < 19; i++) send_bar(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b0);
    send_bar('0, '0, '0, 1'b0);
    random_bars(60);
    settle();

    for (int p = 0; p < 6; p++) begin
      set_window(lengths[p]);
      send_bar('1, '1, '1, 1'b0);
      random_bars(lengths[p] > 7'd20 ? 240 : 170);
      settle();
    end
    for (int p = 0; p < 2; p++) begin
      set_window($urandom_range(2, 63));
      random_bars(120);
      settle();
    end

    $display("Covered %0d bars and %0d results over %0d window settings.",
             bars_sent, result_count, settings_used);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cci_pkg.sv
rtl/core/cci_cell.sv
rtl/core/cci_div.sv
rtl/core/commodity_channel_index.sv
tb/cci_checker.sv
tb/tb_commodity_channel_index.sv
